/* src/bdq_pkg.sv */
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared widths, operation and status codes, and the command and status
// bundles that pass between the deque controller and its datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;
  localparam int FIELD_W  = 32;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_PUSH_FRONT = 3'd0;
  localparam kind_t KIND_PUSH_BACK  = 3'd1;
  localparam kind_t KIND_POP_FRONT  = 3'd2;
  localparam kind_t KIND_POP_BACK   = 3'd3;
  localparam kind_t KIND_REMOVE     = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  // Store read address choice
  typedef enum logic [1:0] {
    ADDR_FRONT    = 2'd0,
    ADDR_BACK     = 2'd1,
    ADDR_POS      = 2'd2,
    ADDR_POS_NEXT = 2'd3
  } addr_sel_t;

  typedef struct packed {
    logic      load;
    logic      push_front;
    logic      push_back;
    logic      pop_front;
    logic      pop_back;
    logic      set_status;
    status_t   status;
    logic      scan_next;
    logic      take_match;
    logic      shift_write;
    logic      remove_done;
    addr_sel_t addr_sel;
    logic      cap_front;
    logic      cap_back;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  empty;
    logic  full;
    logic  multi;
    logic  match;
    logic  scan_last;
  } dp_stat_t;

endpackage

`default_nettype wire

/* src/bdq_in_if.sv */
// ----------------------------------------------------------------------------
// bdq_in_if
// Operation channel: valid/ready with the operation kind and its value.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdq_in_if;
  import bdq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic signed [FIELD_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

`default_nettype wire

/* src/bdq_out_if.sv */
// ----------------------------------------------------------------------------
// bdq_out_if
// Result channel: valid/ready with status, occupancy and the three values.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdq_out_if;
  import bdq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic [OCC_W-1:0]          occupancy;
  logic signed [FIELD_W-1:0] front_value;
  logic signed [FIELD_W-1:0] back_value;
  logic signed [FIELD_W-1:0] taken_value;

  modport source (output valid, output status, output occupancy, output front_value,
                  output back_value, output taken_value, input ready);
  modport sink   (input valid, input status, input occupancy, input front_value,
                  input back_value, input taken_value, output ready);
endinterface

`default_nettype wire

/* src/bounded_deque_with_value_removal.sv */
// ----------------------------------------------------------------------------
// bounded_deque_with_value_removal
// Bounded double-ended queue of signed values with removal by value.
// ----------------------------------------------------------------------------
// Each beat on in_ch is one operation (push front, push back, pop front,
// pop back, or remove the first entry from the front equal to the value);
// each gives exactly one beat on out_ch with status, occupancy, front, back
// and taken value. Operations run one at a time. A push or a flagged
// operation goes straight to its result; a pop then rereads both ends from
// the store unless it empties it. A removal scans from the front until it
// finds the match or runs out of entries, moves each entry behind the match
// forward to close the gap, then rereads both ends unless the store is left
// empty. Each step waits on the single read port of the entry store, whose
// read data is registered, and the scan and shift visit one entry per read.
// A new operation is taken while the previous result still waits on out_ch.
// The store is not cleared after reset; only entries written by a push or
// by the gap-closing shift are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_deque_with_value_removal #(
  parameter int CAPACITY   = bdq_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bdq_in_if.sink    in_ch,
  bdq_out_if.source out_ch
);
  import bdq_pkg::*;

  // Command and status bundles between sequencer and datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer: owns in_ch.ready and the result valid flag
  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: store, pointers, cached ends and the result payload register
  bdq_datapath #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_kind        (in_ch.kind),
    .in_value       (in_ch.value),
    .cmd            (cmd),
    .stat           (stat),
    .out_status     (out_ch.status),
    .out_occupancy  (out_ch.occupancy),
    .out_front_value(out_ch.front_value),
    .out_back_value (out_ch.back_value),
    .out_taken_value(out_ch.taken_value)
  );

endmodule

`default_nettype wire

/* src/bdq_ram.sv */
// ----------------------------------------------------------------------------
// bdq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/bdq_datapath.sv */
// ----------------------------------------------------------------------------
// bdq_datapath
// Entry store, ring pointers, cached end values, scan position and the
// result payload register.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_datapath #(
  parameter int CAPACITY   = bdq_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bdq_pkg::kind_t                    in_kind,
  input  logic signed [bdq_pkg::FIELD_W-1:0] in_value,
  input  bdq_pkg::dp_cmd_t                  cmd,
  output bdq_pkg::dp_stat_t                 stat,
  output logic [bdq_pkg::STATUS_W-1:0]      out_status,
  output logic [bdq_pkg::OCC_W-1:0]         out_occupancy,
  output logic signed [bdq_pkg::FIELD_W-1:0] out_front_value,
  output logic signed [bdq_pkg::FIELD_W-1:0] out_back_value,
  output logic signed [bdq_pkg::FIELD_W-1:0] out_taken_value
);
  import bdq_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;
  localparam int XW = (DATA_WIDTH > FIELD_W) ? DATA_WIDTH : FIELD_W;

  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
                                            input logic [CW-1:0] ofs);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(ofs);
    if (s >= SW'(CAPACITY)) begin
      s = s - SW'(CAPACITY);
    end
    return s[IW-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] to_field(input logic [DATA_WIDTH-1:0] x);
    logic [XW-1:0] t;
    t = XW'(x);
    return t[FIELD_W-1:0];
  endfunction

  kind_t                 op_kind_r;
  logic [DATA_WIDTH-1:0] op_val_r;
  logic [IW-1:0]         front_r, front_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         pos_r, pos_nxt;
  logic [DATA_WIDTH-1:0] front_val_r, front_val_nxt;
  logic [DATA_WIDTH-1:0] back_val_r, back_val_nxt;
  logic [DATA_WIDTH-1:0] taken_r, taken_nxt;
  status_t               status_r, status_nxt;

  logic [STATUS_W-1:0]   out_status_r;
  logic [OCC_W-1:0]      out_occ_r;
  logic [FIELD_W-1:0]    out_front_r;
  logic [FIELD_W-1:0]    out_back_r;
  logic [FIELD_W-1:0]    out_taken_r;

  logic [XW-1:0]         in_ext;
  logic [IW-1:0]         front_dec;
  logic [IW-1:0]         front_inc;
  logic [CW-1:0]         count_m1;
  logic [CW-1:0]         pos_p1;

  logic                  ram_we;
  logic [IW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [IW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  assign in_ext    = XW'($unsigned(in_value));
  assign front_dec = (front_r == '0) ? IW'(CAPACITY - 1) : front_r - 1'b1;
  assign front_inc = (front_r == IW'(CAPACITY - 1)) ? '0 : front_r + 1'b1;
  assign count_m1  = count_r - 1'b1;
  assign pos_p1    = pos_r + 1'b1;

  bdq_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Write port: pushes and the gap-closing shift
  always_comb begin
    ram_we    = cmd.push_front | cmd.push_back | cmd.shift_write;
    ram_waddr = slot_of(front_r, pos_r);
    ram_wdata = ram_rdata;
    if (cmd.push_front) begin
      ram_waddr = front_dec;
      ram_wdata = op_val_r;
    end else if (cmd.push_back) begin
      ram_waddr = slot_of(front_r, count_r);
      ram_wdata = op_val_r;
    end
  end

  always_comb begin
    case (cmd.addr_sel)
      ADDR_FRONT:    ram_raddr = front_r;
      ADDR_BACK:     ram_raddr = slot_of(front_r, count_m1);
      ADDR_POS:      ram_raddr = slot_of(front_r, pos_r);
      ADDR_POS_NEXT: ram_raddr = slot_of(front_r, pos_p1);
      default:       ram_raddr = front_r;
    endcase
  end

  always_comb begin
    front_nxt     = front_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    front_val_nxt = front_val_r;
    back_val_nxt  = back_val_r;
    taken_nxt     = taken_r;
    status_nxt    = status_r;
    if (cmd.load) begin
      pos_nxt    = '0;
      taken_nxt  = '0;
      status_nxt = ST_DONE;
    end
    if (cmd.set_status) begin
      status_nxt = cmd.status;
    end
    if (cmd.push_front) begin
      front_nxt     = front_dec;
      count_nxt     = count_r + 1'b1;
      front_val_nxt = op_val_r;
      if (count_r == '0) begin
        back_val_nxt = op_val_r;
      end
    end
    if (cmd.push_back) begin
      count_nxt    = count_r + 1'b1;
      back_val_nxt = op_val_r;
      if (count_r == '0) begin
        front_val_nxt = op_val_r;
      end
    end
    if (cmd.pop_front) begin
      taken_nxt = front_val_r;
      front_nxt = front_inc;
      count_nxt = count_m1;
    end
    if (cmd.pop_back) begin
      taken_nxt = back_val_r;
      count_nxt = count_m1;
    end
    if (cmd.scan_next || cmd.shift_write) begin
      pos_nxt = pos_p1;
    end
    if (cmd.take_match) begin
      taken_nxt  = ram_rdata;
      status_nxt = ST_DONE;
    end
    if (cmd.remove_done) begin
      count_nxt = count_m1;
    end
    if (cmd.cap_front) begin
      front_val_nxt = ram_rdata;
    end
    if (cmd.cap_back) begin
      back_val_nxt = ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_kind_r <= in_kind;
      op_val_r  <= in_ext[DATA_WIDTH-1:0];
    end
    pos_r       <= pos_nxt;
    front_val_r <= front_val_nxt;
    back_val_r  <= back_val_nxt;
    taken_r     <= taken_nxt;
    status_r    <= status_nxt;
    if (cmd.out_load) begin
      out_status_r <= status_r;
      out_occ_r    <= OCC_W'(count_r);
      out_front_r  <= (count_r == '0) ? '0 : to_field(front_val_r);
      out_back_r   <= (count_r == '0) ? '0 : to_field(back_val_r);
      out_taken_r  <= to_field(taken_r);
    end
  end

  assign stat.kind      = op_kind_r;
  assign stat.empty     = (count_r == '0);
  assign stat.full      = (count_r == CW'(CAPACITY));
  assign stat.multi     = (count_r > CW'(1));
  assign stat.match     = (ram_rdata == op_val_r);
  assign stat.scan_last = (pos_p1 == count_r);

  assign out_status      = out_status_r;
  assign out_occupancy   = out_occ_r;
  assign out_front_value = out_front_r;
  assign out_back_value  = out_back_r;
  assign out_taken_value = out_taken_r;

endmodule

`default_nettype wire

/* src/bdq_ctrl.sv */
// ----------------------------------------------------------------------------
// bdq_ctrl
// Operation sequencer: decodes each operation, walks the scan and shift of a
// removal, refreshes the cached end values and hands the result beat over.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  bdq_pkg::dp_stat_t stat,
  output bdq_pkg::dp_cmd_t  cmd
);
  import bdq_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_DECODE = 10'b0000000010,
    S_SC_RD  = 10'b0000000100,
    S_SC_CMP = 10'b0000001000,
    S_SH_RD  = 10'b0000010000,
    S_SH_WR  = 10'b0000100000,
    S_RF_A   = 10'b0001000000,
    S_RF_B   = 10'b0010000000,
    S_RF_C   = 10'b0100000000,
    S_FINISH = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_FINISH;
        case (stat.kind)
          KIND_PUSH_FRONT: begin
            if (stat.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
            end else begin
              cmd.push_front = 1'b1;
            end
          end
          KIND_PUSH_BACK: begin
            if (stat.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
            end else begin
              cmd.push_back = 1'b1;
            end
          end
          KIND_POP_FRONT: begin
            if (stat.empty) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_EMPTY;
            end else begin
              cmd.pop_front = 1'b1;
              if (stat.multi) begin
                state_nxt = S_RF_A;
              end
            end
          end
          KIND_POP_BACK: begin
            if (stat.empty) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_EMPTY;
            end else begin
              cmd.pop_back = 1'b1;
              if (stat.multi) begin
                state_nxt = S_RF_A;
              end
            end
          end
          KIND_REMOVE: begin
            cmd.set_status = 1'b1;
            if (stat.empty) begin
              cmd.status = ST_EMPTY;
            end else begin
              cmd.status = ST_MISSING;
              state_nxt  = S_SC_RD;
            end
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_SC_RD: begin
        cmd.addr_sel = ADDR_POS;
        state_nxt    = S_SC_CMP;
      end
      S_SC_CMP: begin
        if (stat.match) begin
          cmd.take_match = 1'b1;
          state_nxt      = S_SH_RD;
        end else if (stat.scan_last) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.scan_next = 1'b1;
          state_nxt     = S_SC_RD;
        end
      end
      S_SH_RD: begin
        if (stat.scan_last) begin
          cmd.remove_done = 1'b1;
          state_nxt       = stat.multi ? S_RF_A : S_FINISH;
        end else begin
          cmd.addr_sel = ADDR_POS_NEXT;
          state_nxt    = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd.shift_write = 1'b1;
        state_nxt       = S_SH_RD;
      end
      S_RF_A: begin
        cmd.addr_sel = ADDR_FRONT;
        state_nxt    = S_RF_B;
      end
      S_RF_B: begin
        cmd.cap_front = 1'b1;
        cmd.addr_sel  = ADDR_BACK;
        state_nxt     = S_RF_C;
      end
      S_RF_C: begin
        cmd.cap_back = 1'b1;
        state_nxt    = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/bdq_checker.sv */
// ----------------------------------------------------------------------------
// bdq_checker
// Port-level checks on result beats, bound to the deque top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_checker #(
  parameter int CAPACITY = bdq_pkg::CAPACITY_DEF
) (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [bdq_pkg::STATUS_W-1:0]      out_status,
  input wire logic [bdq_pkg::OCC_W-1:0]         out_occupancy,
  input wire logic signed [bdq_pkg::FIELD_W-1:0] out_front_value,
  input wire logic signed [bdq_pkg::FIELD_W-1:0] out_back_value,
  input wire logic signed [bdq_pkg::FIELD_W-1:0] out_taken_value
);
  import bdq_pkg::*;

  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(CAPACITY);

  // An empty store reports zero at both ends
  a_empty_ends_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_occupancy == '0) |-> (out_front_value == '0) && (out_back_value == '0))
    else $error("empty store reports non-zero end value");

  // A flagged empty operation leaves nothing behind and takes nothing
  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> (out_occupancy == '0) && (out_taken_value == '0))
    else $error("empty status with occupancy or taken value");

  // A rejected push only happens at full occupancy
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> (out_occupancy == OCC_FULL) &&
                                             (out_taken_value == '0))
    else $error("full status below capacity");

  // A missing value takes nothing
  a_missing_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_MISSING) |-> (out_taken_value == '0) &&
                                                (out_occupancy != '0 || CAPACITY >= 32))
    else $error("missing status with taken value or empty store");

  // Hold a result beat until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_taken_value))
    else $error("result beat dropped or changed while stalled");

endmodule

bind bounded_deque_with_value_removal bdq_checker #(
  .CAPACITY(CAPACITY)
) u_bdq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_occupancy  (out_ch.occupancy),
  .out_front_value(out_ch.front_value),
  .out_back_value (out_ch.back_value),
  .out_taken_value(out_ch.taken_value)
);

`default_nettype wire

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bounded deque with removal by value. A short
// table of operations covers empty and full flags, the value extremes, the
// spare kind codes and removal at the front, middle and back. A long random
// run follows, biased in phases to filling, draining or churning the store.
// Every result beat is compared per field with the model or a typed result.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bdq_pkg::*;

  localparam int DEPTH        = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 1020;
  localparam int TAIL_ITEMS   = 150;   // no idling on either side here
  localparam int DRAIN_CYCLES = 100;
  localparam int STALL_LIMIT  = 3000;
  localparam int NUM_ROWS     = 24;

  // Kind codes that the block must ignore
  localparam kind_t KIND_SPARE_5 = 3'd5;
  localparam kind_t KIND_SPARE_6 = 3'd6;
  localparam kind_t KIND_SPARE_7 = 3'd7;

  localparam logic signed [FIELD_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [FIELD_W-1:0] VAL_MIN = 32'sh8000_0000;

  // Biases of the random phases
  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_CHURN = 2;

  typedef struct packed {
    status_t                   status;
    logic [OCC_W-1:0]          occupancy;
    logic signed [FIELD_W-1:0] front_value;
    logic signed [FIELD_W-1:0] back_value;
    logic signed [FIELD_W-1:0] taken_value;
  } deque_result_t;

  // One row of the directed table: an operation, repeated reps times with
  // the value advancing by step, and a typed-in result where typed is set.
  typedef struct packed {
    kind_t                     op;
    logic signed [FIELD_W-1:0] val;
    logic [4:0]                reps;
    logic signed [FIELD_W-1:0] step;
    logic                      typed;
    deque_result_t             want;
  } stim_row_t;

  localparam deque_result_t NOT_TYPED = '0;

  logic clk;
  logic rst_n;

  bdq_in_if  in_ch ();
  bdq_out_if out_ch ();

  bounded_deque_with_value_removal dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Mirror of the store contents, front at index 0
  logic signed [FIELD_W-1:0] deque_contents[$];
  // Results still owed by the block, oldest first
  deque_result_t             pending_results[$];

  int mismatch_cnt = 0;
  int quiet_cycles = 0;
  int idle_pct;      // chance of a gap before a beat, and of a stall on out
  int stall_left   = 0;

  stim_row_t directed_rows [NUM_ROWS] = '{
    // Empty store: every taking operation is flagged
    '{KIND_POP_FRONT,  32'sd0, 5'd1, 32'sd0, 1'b1,
      '{ST_EMPTY, 5'd0, 32'sd0, 32'sd0, 32'sd0}},
    '{KIND_POP_BACK,   32'sd0, 5'd1, 32'sd0, 1'b1,
      '{ST_EMPTY, 5'd0, 32'sd0, 32'sd0, 32'sd0}},
    '{KIND_REMOVE,     32'sd5, 5'd1, 32'sd0, 1'b1,
      '{ST_EMPTY, 5'd0, 32'sd0, 32'sd0, 32'sd0}},
    '{KIND_SPARE_7,    32'sd0, 5'd1, 32'sd0, 1'b1,
      '{ST_DONE,  5'd0, 32'sd0, 32'sd0, 32'sd0}},
    // Value extremes at either end
    '{KIND_PUSH_FRONT, VAL_MAX, 5'd1, 32'sd0, 1'b1,
      '{ST_DONE,  5'd1, VAL_MAX, VAL_MAX, 32'sd0}},
    '{KIND_PUSH_BACK,  VAL_MIN, 5'd1, 32'sd0, 1'b1,
      '{ST_DONE,  5'd2, VAL_MAX, VAL_MIN, 32'sd0}},
    '{KIND_SPARE_5,    -32'sd1, 5'd1, 32'sd0, 1'b1,
      '{ST_DONE,  5'd2, VAL_MAX, VAL_MIN, 32'sd0}},
    '{KIND_SPARE_6,    32'sd123, 5'd1, 32'sd0, 1'b0, NOT_TYPED},
    '{KIND_PUSH_FRONT, -32'sd1, 5'd1, 32'sd0, 1'b0, NOT_TYPED},
    // Fill to capacity: 100..111 at the back, then 0 at the front
    '{KIND_PUSH_BACK,  32'sd100, 5'd12, 32'sd1, 1'b0, NOT_TYPED},
    '{KIND_PUSH_FRONT, 32'sd0, 5'd1, 32'sd0, 1'b0, NOT_TYPED},
    // Full store: pushes at either end are flagged and change nothing
    '{KIND_PUSH_BACK,  32'sd7, 5'd1, 32'sd0, 1'b1,
      '{ST_FULL,  5'd16, 32'sd0, 32'sd111, 32'sd0}},
    '{KIND_PUSH_FRONT, 32'sd9, 5'd1, 32'sd0, 1'b1,
      '{ST_FULL,  5'd16, 32'sd0, 32'sd111, 32'sd0}},
    '{KIND_REMOVE,     32'sd12345, 5'd1, 32'sd0, 1'b1,
      '{ST_MISSING, 5'd16, 32'sd0, 32'sd111, 32'sd0}},
    // Removal of the front entry, an inner one and the back one
    '{KIND_REMOVE,     32'sd0, 5'd1, 32'sd0, 1'b0, NOT_TYPED},
    '{KIND_REMOVE,     VAL_MIN, 5'd1, 32'sd0, 1'b0, NOT_TYPED},
    '{KIND_REMOVE,     32'sd111, 5'd1, 32'sd0, 1'b0, NOT_TYPED},
    '{KIND_POP_FRONT,  32'sd0, 5'd1, 32'sd0, 1'b0, NOT_TYPED},
    '{KIND_POP_BACK,   32'sd0, 5'd1, 32'sd0, 1'b0, NOT_TYPED},
    // Duplicates: only the first from the front goes
    '{KIND_PUSH_BACK,  32'sd50, 5'd2, 32'sd0, 1'b0, NOT_TYPED},
    '{KIND_REMOVE,     32'sd50, 5'd1, 32'sd0, 1'b0, NOT_TYPED},
    // Drain past empty
    '{KIND_POP_BACK,   32'sd0, 5'd14, 32'sd0, 1'b0, NOT_TYPED},
    // Removal of the only entry
    '{KIND_PUSH_FRONT, 32'sd42, 5'd1, 32'sd0, 1'b0, NOT_TYPED},
    '{KIND_REMOVE,     32'sd42, 5'd1, 32'sd0, 1'b0, NOT_TYPED}
  };

  // --------------------------------------------------------------------------
  // Deque model: apply one operation and return the result it owes
  // --------------------------------------------------------------------------
  function automatic deque_result_t apply_deque_op(input kind_t op,
                                                   input logic signed [FIELD_W-1:0] val);
    deque_result_t res;
    int            hit;
    res = '0;
    res.status = ST_DONE;
    hit = -1;
    case (op)
      KIND_PUSH_FRONT: begin
        if (deque_contents.size() >= DEPTH) res.status = ST_FULL;
        else deque_contents.push_front(val);
      end
      KIND_PUSH_BACK: begin
        if (deque_contents.size() >= DEPTH) res.status = ST_FULL;
        else deque_contents.push_back(val);
      end
      KIND_POP_FRONT: begin
        if (deque_contents.size() == 0) res.status = ST_EMPTY;
        else res.taken_value = deque_contents.pop_front();
      end
      KIND_POP_BACK: begin
        if (deque_contents.size() == 0) res.status = ST_EMPTY;
        else res.taken_value = deque_contents.pop_back();
      end
      KIND_REMOVE: begin
        if (deque_contents.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          // search from the front; close the gap behind the first match
          for (int i = 0; i < deque_contents.size() && hit < 0; i++)
            if (deque_contents[i] == val) hit = i;
          if (hit < 0) begin
            res.status = ST_MISSING;
          end else begin
            res.taken_value = deque_contents[hit];
            deque_contents.delete(hit);
          end
        end
      end
      default: ;  // spare kinds leave the store alone
    endcase
    res.occupancy = OCC_W'(deque_contents.size());
    if (deque_contents.size() != 0) begin
      res.front_value = deque_contents[0];
      res.back_value  = deque_contents[$];
    end
    return res;
  endfunction

  // Small values in four rolls of ten so that removals find duplicates, some
  // extremes, and the rest spread over all 32 bits.
  function automatic logic signed [FIELD_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return $signed($urandom_range(0, 8)) - 4;
    if (roll == 4) begin
      case ($urandom_range(0, 3))
        0:       return VAL_MAX;
        1:       return VAL_MIN;
        2:       return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  // --------------------------------------------------------------------------
  // Offer one beat on in_ch, hold it until taken, then log what it owes
  // --------------------------------------------------------------------------
  task automatic send_op(input kind_t op, input logic signed [FIELD_W-1:0] val,
                         input logic typed, input deque_result_t want);
    deque_result_t predicted;
    // drop valid for a burst now and then
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= op;
    in_ch.value <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // advance the model on every beat, even where the result is typed in
    predicted = apply_deque_op(op, val);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Stimulus: directed table, then biased random phases, then a quiet tail
  // --------------------------------------------------------------------------
  initial begin
    int    issued;
    int    mode;
    int    roll;
    int    push_share;
    kind_t op;
    logic signed [FIELD_W-1:0] val;

    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.kind  <= KIND_PUSH_BACK;
    in_ch.value <= '0;
    idle_pct    = 20;
    mode        = MODE_CHURN;
    issued      = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r])
      for (int k = 0; k < directed_rows[r].reps; k++)
        send_op(directed_rows[r].op, directed_rows[r].val + k * directed_rows[r].step,
                directed_rows[r].typed, directed_rows[r].want);

    while (issued < RANDOM_ITEMS) begin
      // pick a new bias and idling level every 64 beats that are not spare kinds
      if (issued % 64 == 0) begin
        mode = $urandom_range(MODE_FILL, MODE_CHURN);
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          default: idle_pct = 35;
        endcase
      end
      if (issued >= RANDOM_ITEMS - TAIL_ITEMS) idle_pct = 0;

      push_share = (mode == MODE_FILL) ? 65 : (mode == MODE_DRAIN) ? 20 : 40;
      roll = $urandom_range(0, 99);
      val  = pick_value();
      if (roll < 3) begin
        op = kind_t'(KIND_SPARE_5 + $urandom_range(0, 2));
      end else if (roll < 3 + push_share) begin
        op = $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
      end else if (roll < 23 + push_share) begin
        op = KIND_REMOVE;
        // mostly aim at a value that is held, at any position
        if (deque_contents.size() != 0 && $urandom_range(0, 3) != 0)
          val = deque_contents[$urandom_range(0, deque_contents.size() - 1)];
      end else begin
        op = $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK;
      end

      send_op(op, val, 1'b0, NOT_TYPED);
      if (op <= KIND_REMOVE) issued++;
    end
    in_ch.valid <= 1'b0;

    // wait for the last results, then a margin for anything stray
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random stall bursts on out_ch.ready
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b1;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 3) begin
      out_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 11);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Check each result beat against the oldest pending result
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    deque_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing pending");
        mismatch_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, out_ch.status);
          mismatch_cnt++;
        end
        if (out_ch.occupancy !== want.occupancy) begin
          $error("occupancy expected %0d got %0d", want.occupancy, out_ch.occupancy);
          mismatch_cnt++;
        end
        if (out_ch.front_value !== want.front_value) begin
          $error("front_value expected %0d got %0d", want.front_value, out_ch.front_value);
          mismatch_cnt++;
        end
        if (out_ch.back_value !== want.back_value) begin
          $error("back_value expected %0d got %0d", want.back_value, out_ch.back_value);
          mismatch_cnt++;
        end
        if (out_ch.taken_value !== want.taken_value) begin
          $error("taken_value expected %0d got %0d", want.taken_value, out_ch.taken_value);
          mismatch_cnt++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when no beat moves on either side for too long
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
